// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the tag stream parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define AST_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define AST_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPLY(name, clk, rst_n, ante, cons)
`define AST_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bitsp_pkg.sv =====
// Shared types and constants of the boot information tag stream parser.
`timescale 1ns / 1ps
package bitsp_pkg;

    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_MODULE = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [31:0] TAG_TYPE_END    = 32'd0;
    localparam logic [31:0] TAG_TYPE_MODULE = 32'd3;
    localparam logic [31:0] TAG_TYPE_MMAP   = 32'd6;
    localparam logic [31:0] MIN_TAG_BYTES   = 32'd8;
    localparam logic [31:0] MIN_BODY_BYTES  = 32'd16;
    localparam logic [31:0] MIN_ENTRY_BYTES = 32'd24;

    localparam int S_DATA_W        = 32;
    localparam int M_DATA_W        = 200;
    localparam int OUT_QUEUE_DEPTH = 4;

    // One queued result; tail adds a done beat after the record.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] base_or_start;
        logic [63:0] length_or_end;
        logic [31:0] region_type;
        logic [31:0] string_offset;
        logic        seen_map;
        logic        seen_module;
        logic        tail;
    } out_entry_t;

    typedef struct packed {
        logic       valid;
        out_entry_t entry;
    } push_t;

    typedef struct packed {
        logic full;
        logic split_pending;
    } qstat_t;

endpackage

// ===== hw/rtl/bitsp_parser.sv =====
// Tag walker: consumes one word per request and produces at most one queue entry.
`timescale 1ns / 1ps
module bitsp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [31:0]        in_word,
    input  logic               in_first,
    output bitsp_pkg::push_t   push,
    output logic               idle
);
    import bitsp_pkg::*;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_SKIP_TAG   = 4'd1;
    localparam logic [3:0] PH_TAG_TYPE   = 4'd2;
    localparam logic [3:0] PH_TAG_SIZE   = 4'd3;
    localparam logic [3:0] PH_MAP_ESIZE  = 4'd4;
    localparam logic [3:0] PH_MAP_EVER   = 4'd5;
    localparam logic [3:0] PH_SKIP_ENTRY = 4'd6;
    localparam logic [3:0] PH_BASE_LO    = 4'd7;
    localparam logic [3:0] PH_BASE_HI    = 4'd8;
    localparam logic [3:0] PH_LEN_LO     = 4'd9;
    localparam logic [3:0] PH_LEN_HI     = 4'd10;
    localparam logic [3:0] PH_ETYPE      = 4'd11;
    localparam logic [3:0] PH_MOD_START  = 4'd12;
    localparam logic [3:0] PH_MOD_END    = 4'd13;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] tag_kind_reg, tag_kind_next;
    logic [31:0] tag_bytes_reg, tag_bytes_next;
    logic [31:0] tag_begin_reg, tag_begin_next;
    logic [31:0] entry_bytes_reg, entry_bytes_next;
    logic [31:0] entry_begin_reg, entry_begin_next;
    logic [63:0] field_low_reg, field_low_next;
    logic [63:0] field_high_reg, field_high_next;
    logic        seen_map_reg, seen_map_next;
    logic        seen_mod_reg, seen_mod_next;

    logic [3:0]  eff_phase;
    logic [31:0] size_sel;
    logic [33:0] nt_sum;
    logic [33:0] nt_addr;
    logic        nt_end;
    logic [32:0] tend_sum;
    logic [31:0] tag_end;
    logic [32:0] try_begin;
    logic [33:0] try_stop;
    logic        try_ok;
    logic        do_finish, do_next, do_try, emit_rec;
    out_entry_t  rec;

    // Skip phases turn into the tag header or entry base phase at their start.
    always_comb begin
        if (phase_reg == PH_SKIP_TAG && pos_reg >= tag_begin_reg) begin
            eff_phase = PH_TAG_TYPE;
        end else if (phase_reg == PH_SKIP_ENTRY && pos_reg >= entry_begin_reg) begin
            eff_phase = PH_BASE_LO;
        end else begin
            eff_phase = phase_reg;
        end
    end

    // Next tag start, rounded up to 8 bytes; end if its header passes the total size.
    assign size_sel = (eff_phase == PH_TAG_SIZE) ? in_word : tag_bytes_reg;
    assign nt_sum   = {2'b00, tag_begin_reg} + {2'b00, size_sel} + 34'd7;
    assign nt_addr  = {nt_sum[33:3], 3'b000};
    assign nt_end   = ({1'b0, nt_addr} + 35'd8) > {3'b000, total_reg};

    // Entry must fit inside the tag, whose end saturates at 32 bits.
    assign tend_sum  = {1'b0, tag_begin_reg} + {1'b0, tag_bytes_reg};
    assign tag_end   = tend_sum[32] ? 32'hFFFF_FFFF : tend_sum[31:0];
    assign try_begin = (eff_phase == PH_ETYPE)
                     ? {1'b0, entry_begin_reg} + {1'b0, entry_bytes_reg}
                     : {1'b0, tag_begin_reg} + 33'd16;
    assign try_stop  = {1'b0, try_begin} + {2'b00, entry_bytes_reg};
    assign try_ok    = (entry_bytes_reg[1:0] == 2'b00)
                    && (entry_bytes_reg >= MIN_ENTRY_BYTES)
                    && (try_stop <= {2'b00, tag_end});

    always_comb begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        total_next       = total_reg;
        tag_kind_next    = tag_kind_reg;
        tag_bytes_next   = tag_bytes_reg;
        tag_begin_next   = tag_begin_reg;
        entry_bytes_next = entry_bytes_reg;
        entry_begin_next = entry_begin_reg;
        field_low_next   = field_low_reg;
        field_high_next  = field_high_reg;
        seen_map_next    = seen_map_reg;
        seen_mod_next    = seen_mod_reg;
        do_finish        = 1'b0;
        do_next          = 1'b0;
        do_try           = 1'b0;
        emit_rec         = 1'b0;
        rec              = '0;

        if (in_accept) begin
            if (in_first) begin
                total_next    = in_word;
                pos_next      = 32'd4;
                seen_map_next = 1'b0;
                seen_mod_next = 1'b0;
                if (in_word < MIN_BODY_BYTES) begin
                    do_finish = 1'b1;
                end else begin
                    tag_begin_next = 32'd8;
                    phase_next     = PH_SKIP_TAG;
                end
            end else if (phase_reg != PH_IDLE) begin
                pos_next   = pos_reg + 32'd4;
                phase_next = eff_phase;
                case (eff_phase)
                    PH_TAG_TYPE: begin
                        tag_kind_next = in_word;
                        if (in_word == TAG_TYPE_END) begin
                            do_finish = 1'b1;
                        end else begin
                            phase_next = PH_TAG_SIZE;
                        end
                    end
                    PH_TAG_SIZE: begin
                        tag_bytes_next = in_word;
                        if (in_word < MIN_TAG_BYTES) begin
                            do_finish = 1'b1;
                        end else if (tag_kind_reg == TAG_TYPE_MMAP
                                     && in_word >= MIN_BODY_BYTES) begin
                            seen_map_next = 1'b1;
                            phase_next    = PH_MAP_ESIZE;
                        end else if (tag_kind_reg == TAG_TYPE_MODULE
                                     && in_word >= MIN_BODY_BYTES) begin
                            seen_mod_next = 1'b1;
                            phase_next    = PH_MOD_START;
                        end else begin
                            do_next = 1'b1;
                        end
                    end
                    PH_MAP_ESIZE: begin
                        entry_bytes_next = in_word;
                        phase_next       = PH_MAP_EVER;
                    end
                    PH_MAP_EVER: begin
                        do_try = 1'b1;
                    end
                    PH_BASE_LO: begin
                        field_low_next = {32'd0, in_word};
                        phase_next     = PH_BASE_HI;
                    end
                    PH_BASE_HI: begin
                        field_low_next = {in_word, field_low_reg[31:0]};
                        phase_next     = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        field_high_next = {32'd0, in_word};
                        phase_next      = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        field_high_next = {in_word, field_high_reg[31:0]};
                        phase_next      = PH_ETYPE;
                    end
                    PH_ETYPE: begin
                        emit_rec          = 1'b1;
                        rec.kind          = KIND_REGION;
                        rec.base_or_start = field_low_reg;
                        rec.length_or_end = field_high_reg;
                        rec.region_type   = in_word;
                        do_try            = 1'b1;
                    end
                    PH_MOD_START: begin
                        field_low_next = {32'd0, in_word};
                        phase_next     = PH_MOD_END;
                    end
                    PH_MOD_END: begin
                        field_high_next   = {32'd0, in_word};
                        emit_rec          = 1'b1;
                        rec.kind          = KIND_MODULE;
                        rec.base_or_start = field_low_reg;
                        rec.length_or_end = {32'd0, in_word};
                        rec.string_offset = tag_begin_reg + 32'd16;
                        do_next           = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (do_try) begin
            if (try_ok) begin
                entry_begin_next = try_begin[31:0];
                phase_next       = PH_SKIP_ENTRY;
            end else begin
                do_next = 1'b1;
            end
        end
        if (do_next) begin
            if (nt_end) begin
                do_finish = 1'b1;
            end else begin
                tag_begin_next = nt_addr[31:0];
                phase_next     = PH_SKIP_TAG;
            end
        end
        if (do_finish) begin
            phase_next = PH_IDLE;
        end

        push.valid             = emit_rec || do_finish;
        push.entry             = rec;
        push.entry.seen_map    = seen_map_next;
        push.entry.seen_module = seen_mod_next;
        push.entry.tail        = emit_rec && do_finish;
        if (!emit_rec) begin
            push.entry.kind = KIND_DONE;
        end
    end

    assign idle = (phase_reg == PH_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            pos_reg         <= '0;
            total_reg       <= '0;
            tag_kind_reg    <= '0;
            tag_bytes_reg   <= '0;
            tag_begin_reg   <= '0;
            entry_bytes_reg <= '0;
            entry_begin_reg <= '0;
            seen_map_reg    <= 1'b0;
            seen_mod_reg    <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            total_reg       <= total_next;
            tag_kind_reg    <= tag_kind_next;
            tag_bytes_reg   <= tag_bytes_next;
            tag_begin_reg   <= tag_begin_next;
            entry_bytes_reg <= entry_bytes_next;
            entry_begin_reg <= entry_begin_next;
            seen_map_reg    <= seen_map_next;
            seen_mod_reg    <= seen_mod_next;
        end
    end

    always_ff @(posedge aclk) begin
        field_low_reg  <= field_low_next;
        field_high_reg <= field_high_next;
    end

endmodule

// ===== hw/rtl/bitsp_out_queue.sv =====
// Result queue: holds parsed records and splits a record with trailing done into two beats.
`timescale 1ns / 1ps
module bitsp_out_queue #(
    parameter int Depth = bitsp_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bitsp_pkg::push_t                 push,
    output logic                             not_full,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bitsp_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    output bitsp_pkg::qstat_t                stat
);
    import bitsp_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    out_entry_t      slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            sub_reg, sub_next;
    out_entry_t      head;
    logic            beat_done;
    logic            take, pop;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_full  = (cnt_reg != CntFull);
    assign m_tvalid  = (cnt_reg != '0);
    assign beat_done = sub_reg || (head.kind == KIND_DONE);
    assign take      = m_tvalid && m_tready;
    // Release the slot once its last beat goes out.
    assign pop       = take && (sub_reg || !head.tail);

    always_comb begin
        m_tuser = beat_done ? KIND_DONE : head.kind;
        m_tlast = beat_done;
        if (beat_done) begin
            m_tdata = {6'd0, head.seen_module, head.seen_map, 192'd0};
        end else begin
            m_tdata = {6'd0, 2'b00, head.string_offset, head.region_type,
                       head.length_or_end, head.base_or_start};
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            sub_next    = 1'b0;
        end else if (take) begin
            sub_next = 1'b1;
        end
        case ({push.valid, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    assign stat.full          = !not_full;
    assign stat.split_pending = m_tvalid && !sub_reg && head.tail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== hw/rtl/boot_info_tag_stream_parser_unit.sv =====
// Top level of the boot information tag stream parser.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Input stream: one 32-bit little-endian word of the boot information per request;
// s_tuser marks the first word (total size) and restarts the walk.
// Output stream: one record per request; m_tuser is the kind (region, module, done),
// m_tlast marks the done record that closes a structure.
// Each accepted word is parsed in the cycle it is taken; its records are written to the
// result queue registers and leave from there in order.
// Input rate is one word per cycle while the result queue has room (depth set by
// OutQueueDepth). A word that yields a record plus done takes two output beats from
// the same queue slot; such words are several words apart, so with the receiver
// always ready the queue never fills and s_tready stays high.
// When the receiver stalls, the queue fills and s_tready drops; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue and parks the parser until the
// next first word; words before that are dropped without results.
module boot_info_tag_stream_parser_unit #(
    parameter int OutQueueDepth = bitsp_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bitsp_pkg::S_DATA_W-1:0]   s_tdata,  // [31:0] word
    input  logic                             s_tuser,  // [0] first
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [63:0] base_or_start, [127:64] length_or_end, [159:128] region_type,
    // [191:160] string_offset, [192] found_memory_map, [193] found_module
    output logic [bitsp_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser,  // [1:0] kind
    output logic                             m_tlast
);
    import bitsp_pkg::*;

    logic   in_accept;
    push_t  push;
    qstat_t q_stat;
    logic   core_idle;

    assign in_accept = s_tvalid && s_tready;

    bitsp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_word   (s_tdata),
        .in_first  (s_tuser),
        .push      (push),
        .idle      (core_idle)
    );

    bitsp_out_queue #(
        .Depth (OutQueueDepth)
    ) u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .not_full (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (q_stat)
    );

    `AST_NEXT(a_split_done, aclk, aresetn, q_stat.split_pending && m_tready, m_tvalid && m_tlast && m_tuser == KIND_DONE)
    `AST_IMPLY(a_full_has_data, aclk, aresetn, q_stat.full, m_tvalid && !s_tready)
    `AST_NEXT(a_done_parks, aclk, aresetn, push.valid && (push.entry.kind == KIND_DONE || push.entry.tail), core_idle)

endmodule

// ===== verif/boot_info_tag_stream_parser_unit_tb.sv =====
// Self-checking testbench for the boot information tag stream parser.
`timescale 1ns / 1ps
module boot_info_tag_stream_parser_unit_tb;
    import bitsp_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          ENTRY_WORDS   = 6;
    localparam logic [31:0] INFO_MIN_BYTES = 32'd16;
    localparam logic [31:0] FIRST_TAG_AT   = 32'd8;
    localparam logic [31:0] BODY_OFFSET    = 32'd16;
    localparam logic [31:0] TAG_TYPE_LOADER_NAME = 32'd2;
    localparam logic [31:0] REGION_AVAILABLE     = 32'd1;

    typedef enum logic [3:0] {
        WALK_IDLE, WALK_SKIP_TAG, WALK_TAG_TYPE, WALK_TAG_SIZE, WALK_ENTRY_SIZE,
        WALK_ENTRY_VER, WALK_SKIP_ENTRY, WALK_BASE_LO, WALK_BASE_HI, WALK_LEN_LO,
        WALK_LEN_HI, WALK_REGION_TYPE, WALK_MOD_START, WALK_MOD_END
    } walk_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] base;
        logic [63:0] span;
        logic [31:0] rtype;
        logic [31:0] str_off;
        logic        map_flag;
        logic        mod_flag;
        logic        last;
    } boot_record_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    boot_info_tag_stream_parser_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Walker state, mirrors the parser.
    walk_phase_t walk_phase      = WALK_IDLE;
    logic [31:0] cur_pos         = '0;
    logic [31:0] info_total      = '0;
    logic [31:0] cur_tag_type    = '0;
    logic [31:0] cur_tag_size    = '0;
    logic [31:0] cur_tag_start   = '0;
    logic [31:0] cur_entry_size  = '0;
    logic [31:0] cur_entry_start = '0;
    logic [63:0] held_lo         = '0;
    logic [63:0] held_hi         = '0;
    logic        map_seen        = 1'b0;
    logic        module_seen     = 1'b0;

    boot_record_t pending_records[$];
    boot_record_t sink_want;
    logic [31:0]  frame_words[$];

    int src_idle_pct  = 38;
    int sink_idle_pct = 79;
    int words_sent    = 0;
    int mismatch_count = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    function automatic void expect_record(input logic [1:0] k, input logic [63:0] a, b,
                                          input logic [31:0] rt, so, input logic fm, fo, lst);
        boot_record_t r;
        r.kind = k;
        r.base = a;
        r.span = b;
        r.rtype = rt;
        r.str_off = so;
        r.map_flag = fm;
        r.mod_flag = fo;
        r.last = lst;
        pending_records.push_back(r);
    endfunction

    function automatic void close_info();
        expect_record(KIND_DONE, '0, '0, '0, '0, map_seen, module_seen, 1'b1);
        walk_phase = WALK_IDLE;
    endfunction

    function automatic void step_to_next_tag();
        logic [63:0] nxt;
        nxt = ({32'd0, cur_tag_start} + {32'd0, cur_tag_size} + 64'd7) & ~64'd7;
        if (nxt + {32'd0, MIN_TAG_BYTES} > {32'd0, info_total}) begin
            close_info();
        end else begin
            cur_tag_start = nxt[31:0];
            walk_phase = WALK_SKIP_TAG;
        end
    endfunction

    function automatic void open_entry(input logic [63:0] at);
        logic [63:0] tag_end;
        tag_end = {32'd0, cur_tag_start} + {32'd0, cur_tag_size};
        // clamp the tag end to the 32-bit address space
        if (tag_end > 64'hFFFF_FFFF) tag_end = 64'hFFFF_FFFF;
        if (cur_entry_size[1:0] != 2'b00 || cur_entry_size < MIN_ENTRY_BYTES ||
            at + {32'd0, cur_entry_size} > tag_end) begin
            step_to_next_tag();
        end else begin
            cur_entry_start = at[31:0];
            walk_phase = WALK_SKIP_ENTRY;
        end
    endfunction

    function automatic void walk_word(input logic [31:0] w, input logic is_first);
        logic [31:0] p;
        if (is_first) begin
            walk_phase = WALK_IDLE;
            cur_tag_type = '0;
            cur_tag_size = '0;
            cur_entry_size = '0;
            cur_entry_start = '0;
            held_lo = '0;
            held_hi = '0;
            map_seen = 1'b0;
            module_seen = 1'b0;
            info_total = w;
            cur_pos = 32'd4;
            if (w < INFO_MIN_BYTES) begin
                close_info();
            end else begin
                cur_tag_start = FIRST_TAG_AT;
                walk_phase = WALK_SKIP_TAG;
            end
        end else if (walk_phase != WALK_IDLE) begin
            p = cur_pos;
            cur_pos = p + 32'd4;
            if (walk_phase == WALK_SKIP_TAG && p >= cur_tag_start) walk_phase = WALK_TAG_TYPE;
            if (walk_phase == WALK_SKIP_ENTRY && p >= cur_entry_start) walk_phase = WALK_BASE_LO;
            case (walk_phase)
                WALK_TAG_TYPE: begin
                    cur_tag_type = w;
                    if (w == TAG_TYPE_END) close_info();
                    else walk_phase = WALK_TAG_SIZE;
                end
                WALK_TAG_SIZE: begin
                    cur_tag_size = w;
                    if (w < MIN_TAG_BYTES) begin
                        close_info();
                    end else if (cur_tag_type == TAG_TYPE_MMAP && w >= MIN_BODY_BYTES) begin
                        map_seen = 1'b1;
                        walk_phase = WALK_ENTRY_SIZE;
                    end else if (cur_tag_type == TAG_TYPE_MODULE && w >= MIN_BODY_BYTES) begin
                        module_seen = 1'b1;
                        walk_phase = WALK_MOD_START;
                    end else begin
                        step_to_next_tag();
                    end
                end
                WALK_ENTRY_SIZE: begin
                    cur_entry_size = w;
                    walk_phase = WALK_ENTRY_VER;
                end
                WALK_ENTRY_VER: open_entry({32'd0, cur_tag_start} + {32'd0, BODY_OFFSET});
                WALK_BASE_LO: begin
                    held_lo = {32'd0, w};
                    walk_phase = WALK_BASE_HI;
                end
                WALK_BASE_HI: begin
                    held_lo[63:32] = w;
                    walk_phase = WALK_LEN_LO;
                end
                WALK_LEN_LO: begin
                    held_hi = {32'd0, w};
                    walk_phase = WALK_LEN_HI;
                end
                WALK_LEN_HI: begin
                    held_hi[63:32] = w;
                    walk_phase = WALK_REGION_TYPE;
                end
                WALK_REGION_TYPE: begin
                    expect_record(KIND_REGION, held_lo, held_hi, w, '0, 1'b0, 1'b0, 1'b0);
                    open_entry({32'd0, cur_entry_start} + {32'd0, cur_entry_size});
                end
                WALK_MOD_START: begin
                    held_lo = {32'd0, w};
                    walk_phase = WALK_MOD_END;
                end
                WALK_MOD_END: begin
                    held_hi = {32'd0, w};
                    expect_record(KIND_MODULE, held_lo, held_hi, '0, cur_tag_start + BODY_OFFSET,
                                  1'b0, 1'b0, 1'b0);
                    step_to_next_tag();
                end
                default: ;
            endcase
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got, want);
        if (got !== want) report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    // Receiver: check each accepted record, then pick tready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_records.size() == 0) begin
                report_mismatch("record arrived with nothing expected");
            end else begin
                sink_want = pending_records.pop_front();
                compare_field("kind", m_tuser, sink_want.kind);
                compare_field("base_or_start", m_tdata[63:0], sink_want.base);
                compare_field("length_or_end", m_tdata[127:64], sink_want.span);
                compare_field("region_type", m_tdata[159:128], sink_want.rtype);
                compare_field("string_offset", m_tdata[191:160], sink_want.str_off);
                compare_field("found_memory_map", m_tdata[192], sink_want.map_flag);
                compare_field("found_module", m_tdata[193], sink_want.mod_flag);
                compare_field("pad", m_tdata[M_DATA_W-1:194], '0);
                compare_field("last", m_tlast, sink_want.last);
            end
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial begin : watchdog
        int n;
        for (n = 0; n < CYCLE_LIMIT; n++) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(input logic [31:0] w, input logic is_first);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= is_first;
        do @(posedge aclk); while (!s_tready);
        walk_word(w, is_first);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_words.size(); i++) send_word(frame_words[i], i == 0);
        words_sent += frame_words.size();
    endtask

    task automatic wait_drain();
        if (pending_records.size() != 0) begin
            // stop offering while waiting so the last request is not taken again
            s_tvalid <= 1'b0;
            while (pending_records.size() != 0) @(posedge aclk);
        end
    endtask

    function automatic void pad_to_tag_boundary();
        while (frame_words.size() % 2 != 0) frame_words.push_back($urandom);
    endfunction

    function automatic void add_map_tag(input int n_ent);
        int ent_words;
        ent_words = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 8) : ENTRY_WORDS;
        frame_words.push_back(TAG_TYPE_MMAP);
        frame_words.push_back(BODY_OFFSET + n_ent * ent_words * 4);
        frame_words.push_back(ent_words * 4);
        frame_words.push_back($urandom_range(0, 1));
        repeat (n_ent) begin
            repeat (4) frame_words.push_back($urandom);
            frame_words.push_back(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5));
            repeat (ent_words - 5) frame_words.push_back($urandom);
        end
        pad_to_tag_boundary();
    endfunction

    function automatic void add_module_tag();
        int slen;
        slen = $urandom_range(0, 12);
        frame_words.push_back(TAG_TYPE_MODULE);
        frame_words.push_back(BODY_OFFSET + slen);
        frame_words.push_back($urandom);
        frame_words.push_back($urandom);
        repeat ((slen + 3) / 4) frame_words.push_back($urandom);
        pad_to_tag_boundary();
    endfunction

    function automatic void add_other_tag();
        int tsize;
        if ($urandom_range(0, 3) == 0) begin
            // map or module tag too short to carry a body
            tsize = $urandom_range(8, 15);
            frame_words.push_back($urandom_range(0, 1) ? TAG_TYPE_MMAP : TAG_TYPE_MODULE);
        end else begin
            tsize = $urandom_range(8, 40);
            frame_words.push_back($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(7, 40));
        end
        frame_words.push_back(tsize);
        repeat ((tsize - 5) / 4) frame_words.push_back($urandom);
        pad_to_tag_boundary();
    endfunction

    function automatic void add_broken_tag();
        case ($urandom_range(0, 4))
            0: begin
                frame_words.push_back($urandom_range(1, 40));
                frame_words.push_back($urandom_range(0, 7));
            end
            1: begin
                frame_words.push_back(TAG_TYPE_MMAP);
                frame_words.push_back(BODY_OFFSET + MIN_ENTRY_BYTES);
                frame_words.push_back($urandom_range(0, 40));
                frame_words.push_back($urandom);
                repeat (ENTRY_WORDS) frame_words.push_back($urandom);
            end
            2: begin
                // entry runs past the tag end
                frame_words.push_back(TAG_TYPE_MMAP);
                frame_words.push_back(BODY_OFFSET + $urandom_range(0, 23));
                frame_words.push_back(MIN_ENTRY_BYTES);
                frame_words.push_back($urandom);
                repeat (ENTRY_WORDS) frame_words.push_back($urandom);
            end
            3: begin
                frame_words.push_back($urandom);
                frame_words.push_back($urandom);
                repeat ($urandom_range(0, 6)) frame_words.push_back($urandom);
            end
            default: begin
                frame_words.push_back(TAG_TYPE_END);
                frame_words.push_back($urandom);
            end
        endcase
        pad_to_tag_boundary();
    endfunction

    function automatic void build_random_info();
        int style;
        int pick;
        int keep;
        frame_words.delete();
        frame_words.push_back('0);
        frame_words.push_back($urandom);
        style = $urandom_range(0, 99);
        if (style < 8) begin
            frame_words[0] = $urandom;
            repeat ($urandom_range(1, 12)) frame_words.push_back($urandom);
        end else begin
            repeat ($urandom_range(0, 4)) begin
                pick = $urandom_range(0, 99);
                if (style >= 88 && pick < 30) add_broken_tag();
                else if (pick < 45) add_map_tag($urandom_range(0, 3));
                else if (pick < 75) add_module_tag();
                else add_other_tag();
            end
            if ($urandom_range(0, 99) < 85) begin
                frame_words.push_back(TAG_TYPE_END);
                frame_words.push_back(MIN_TAG_BYTES);
            end
            frame_words[0] = frame_words.size() * 4;
            if (style >= 75 && style < 88) begin
                case ($urandom_range(0, 2))
                    0: frame_words[0] = $urandom_range(0, frame_words.size() * 4 + 16);
                    1: begin
                        // cut short; the next first word drops the rest
                        keep = $urandom_range(1, frame_words.size());
                        while (frame_words.size() > keep)
                            frame_words.delete(frame_words.size() - 1);
                    end
                    default: frame_words[0] = $urandom;
                endcase
            end
        end
    endfunction

    task automatic test_stray_words();
        send_word(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_short_total();
        frame_words = {INFO_MIN_BYTES - 32'd1};
        send_frame();
        send_word($urandom, 1'b0);
    endtask

    task automatic test_module_then_done();
        // total ends right after the module tag: module and done on one word
        frame_words = {32'd24, 32'd0, TAG_TYPE_MODULE, MIN_BODY_BYTES, 32'hFFFF_FFFF, 32'd0};
        send_frame();
        wait_drain();
    endtask

    task automatic test_region_then_done();
        frame_words = {32'd48, $urandom, TAG_TYPE_MMAP, 32'd40, MIN_ENTRY_BYTES, 32'd0,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, REGION_AVAILABLE,
                       $urandom};
        send_frame();
        wait_drain();
    endtask

    task automatic test_short_tag_size();
        frame_words = {32'd64, 32'd0, TAG_TYPE_LOADER_NAME, MIN_TAG_BYTES - 32'd1};
        send_frame();
    endtask

    task automatic test_bad_entry_size();
        // left unfinished on purpose; the next first word restarts the walk
        frame_words = {32'd40, 32'd0, TAG_TYPE_MMAP, MIN_BODY_BYTES, 32'd26, 32'd0};
        send_frame();
    endtask

    task automatic test_position_overflow();
        frame_words = {32'hFFFF_FFFF, 32'd0, TAG_TYPE_MMAP, 32'hFFFF_FFFC, MIN_ENTRY_BYTES,
                       32'd0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        send_frame();
        frame_words = {32'hFFFF_FFFF, 32'd0, TAG_TYPE_LOADER_NAME, 32'hFFFF_FFF0};
        send_frame();
        wait_drain();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        hold_requests++;
        repeat (4) begin
            frame_words.delete();
            frame_words.push_back('0);
            frame_words.push_back($urandom);
            add_map_tag(3);
            add_module_tag();
            frame_words.push_back(TAG_TYPE_END);
            frame_words.push_back(MIN_TAG_BYTES);
            frame_words[0] = frame_words.size() * 4;
            send_frame();
        end
        wait_drain();
    endtask

    task automatic test_random_infos(input int n_words, input int src_pct, input int sink_pct);
        int target;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        target = words_sent + n_words;
        while (words_sent < target) begin
            build_random_info();
            send_frame();
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
            if ($urandom_range(0, 19) == 0) wait_drain();
        end
        wait_drain();
    endtask

    initial begin : stimulus
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_stray_words();
        test_short_total();
        test_module_then_done();
        test_region_then_done();
        test_short_tag_size();
        test_bad_entry_size();
        test_position_overflow();
        test_backpressure();
        test_random_infos(400, 38, 79);
        test_random_infos(400, 79, 38);
        test_random_infos(400, 0, 0);
        s_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && pending_records.size() != 0; n++) @(posedge aclk);
        if (pending_records.size() != 0)
            report_mismatch($sformatf("%0d records never arrived", pending_records.size()));
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
